FILE: rtl/tcg_pkg.sv
// Shared types and constants for the text console glyph renderer.
package tcg_pkg;

   localparam int MAX_GLYPHS       = 256;
   localparam int MAX_GLYPH_HEIGHT = 32;
   localparam int MAX_GLYPH_WIDTH  = 32;
   localparam int TAB_SIZE         = 8;
   localparam int VT_LINES         = 4;

   localparam int GLYPH_IDX_W = $clog2(MAX_GLYPHS);
   localparam int ROW_IDX_W   = $clog2(MAX_GLYPH_HEIGHT);
   localparam int FONT_DEPTH  = MAX_GLYPHS * MAX_GLYPH_HEIGHT;
   localparam int FONT_AW     = $clog2(FONT_DEPTH);
   localparam int BITS_W      = 32;
   localparam int PIX_W       = 14;
   localparam int COORD_W     = 8;
   localparam int DIM_W       = 6;
   localparam int GCOUNT_W    = 9;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_COUNT  = 3'd4;

   localparam logic [COORD_W-1:0]  RST_COLUMNS      = 8'd80;
   localparam logic [COORD_W-1:0]  RST_ROWS         = 8'd25;
   localparam logic [DIM_W-1:0]    RST_GLYPH_WIDTH  = 6'd8;
   localparam logic [DIM_W-1:0]    RST_GLYPH_HEIGHT = 6'd16;
   localparam logic [GCOUNT_W-1:0] RST_GLYPH_COUNT  = 9'd256;

   localparam logic [7:0] CH_BEL   = 8'd7;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_VT    = 8'd11;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam logic OP_PUT_CHAR  = 1'b0;
   localparam logic OP_LOAD_ROW  = 1'b1;
   localparam logic KIND_DRAW    = 1'b0;
   localparam logic KIND_SCROLL  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_FETCH,
      ST_ROWS,
      ST_LINE
   } state_type;

   typedef enum logic [2:0] {
      CLS_NOP,
      CLS_BS,
      CLS_LF,
      CLS_VT,
      CLS_CR,
      CLS_TAB,
      CLS_DRAW
   } char_class_type;

endpackage

FILE: rtl/text_console_glyph_renderer.sv
// Text console glyph renderer: font store, cursor sequencer and result register.
//
// channel | dir | handshake                   | payload
// req     | in  | req_tvalid / req_tready     | tuser op; tdata char, glyph, row, bits
// rsp     | out | rsp_tvalid / rsp_tready     | tuser kind; tdata x, y, bits, lines; tlast
// csr     | in  | csr_valid / csr_ready       | csr_index, csr_wdata
//
// A font row load is written on accept; a control code goes on to a line check when it
// moves the line or wraps. A printable or backspace runs two multiplier passes, one font
// fetch, then one row per cycle from the font RAM unless rsp stalls, and a line check on wrap.
// A stalled rsp holds the sequencer on the current row or scroll result.
// Synchronous reset restores register defaults and homes the cursor; the
// font RAM is not cleared.
module text_console_glyph_renderer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] char_code, [15:8] load_glyph, [20:16] load_row, [52:21] load_bits
   input  logic [tcg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] op
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [13:0] pixel_x, [27:14] pixel_y, [59:28] row_bits, [67:60] scroll_lines
   output logic [tcg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] kind
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tcg_pkg::*;

   state_type state_ff, state_in;

   logic [COORD_W-1:0]     columns_ff, columns_in;
   logic [COORD_W-1:0]     rows_ff, rows_in;
   logic [DIM_W-1:0]       gw_ff, gw_in;
   logic [DIM_W-1:0]       gh_ff, gh_in;
   logic [GCOUNT_W-1:0]    gcount_ff, gcount_in;

   logic [COORD_W-1:0]     cursor_col_ff, cursor_col_in;
   logic [COORD_W-1:0]     cursor_line_ff, cursor_line_in;

   logic [GLYPH_IDX_W-1:0] glyph_ff, glyph_in;
   logic [COORD_W-1:0]     x_col_ff, x_col_in;
   logic [COORD_W-1:0]     y_line_ff, y_line_in;
   logic                   check_ff, check_in;
   logic [COORD_W:0]       target_ff, target_in;
   logic [ROW_IDX_W-1:0]   row_ff, row_in;
   logic [PIX_W-1:0]       base_x_ff, base_x_in;
   logic [PIX_W-1:0]       base_y_ff, base_y_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [PIX_W-1:0]       rsp_px_ff, rsp_px_in;
   logic [PIX_W-1:0]       rsp_py_ff, rsp_py_in;
   logic [BITS_W-1:0]      rsp_bits_ff, rsp_bits_in;
   logic [COORD_W-1:0]     rsp_lines_ff, rsp_lines_in;

   logic                   req_op;
   logic [7:0]             req_char;
   logic [GLYPH_IDX_W-1:0] req_glyph;
   logic [ROW_IDX_W-1:0]   req_row;
   logic [BITS_W-1:0]      req_bits;
   logic                   req_accept;
   logic                   out_free;

   logic [COORD_W-1:0]     ncol, nrow;
   logic [DIM_W-1:0]       gw_eff, gh_eff, gh_m1;
   logic [BITS_W-1:0]      row_mask;
   logic                   last_row;
   logic                   scroll_need;
   logic [COORD_W:0]       scroll_diff;
   logic [COORD_W-1:0]     scroll_lines;

   char_class_type         cls;
   logic [COORD_W-1:0]     bs_col;
   logic [7:0]             draw_code;
   logic [GLYPH_IDX_W-1:0] sel_glyph;
   logic [COORD_W:0]       col_pre, col_sub, col_new;
   logic                   wrap;
   logic                   dec_draw, dec_check;
   logic [COORD_W:0]       dec_target;
   logic [COORD_W-1:0]     dec_x_col;

   logic                   rd_en;
   logic [FONT_AW-1:0]     rd_addr;
   logic [BITS_W-1:0]      rd_data;
   logic                   wr_en;
   logic [COORD_W-1:0]     mul_a;
   logic [DIM_W-1:0]       mul_b;
   logic [PIX_W-1:0]       mul_prod;

   assign req_op    = req_tuser;
   assign req_char  = req_tdata[7:0];
   assign req_glyph = req_tdata[15:8];
   assign req_row   = req_tdata[20:16];
   assign req_bits  = req_tdata[52:21];

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign ncol   = (columns_ff == '0) ? 8'd1 : columns_ff;
   assign nrow   = (rows_ff == '0) ? 8'd1 : rows_ff;
   assign gw_eff = (gw_ff == '0) ? 6'd1 :
                   (gw_ff > 6'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH) : gw_ff;
   assign gh_eff = (gh_ff == '0) ? 6'd1 :
                   (gh_ff > 6'(MAX_GLYPH_HEIGHT)) ? 6'(MAX_GLYPH_HEIGHT) : gh_ff;
   assign gh_m1  = gh_eff - 6'd1;
   assign row_mask = {BITS_W{1'b1}} >> (6'(MAX_GLYPH_WIDTH) - gw_eff);
   assign last_row = (row_ff == gh_m1[ROW_IDX_W-1:0]);

   assign scroll_need  = (target_ff >= {1'b0, nrow});
   assign scroll_diff  = target_ff - {1'b0, nrow} + 9'd1;
   assign scroll_lines = scroll_diff[COORD_W] ? 8'hFF : scroll_diff[COORD_W-1:0];

   // character decode
   always_comb begin
      case (req_char)
         CH_BEL:  cls = CLS_NOP;
         CH_FF:   cls = CLS_NOP;
         CH_BS:   cls = CLS_BS;
         CH_LF:   cls = CLS_LF;
         CH_VT:   cls = CLS_VT;
         CH_CR:   cls = CLS_CR;
         CH_TAB:  cls = CLS_TAB;
         default: cls = CLS_DRAW;
      endcase
   end

   always_comb begin
      bs_col    = (cursor_col_ff == '0) ? '0 : cursor_col_ff - 8'd1;
      draw_code = (cls == CLS_BS) ? CH_SPACE : req_char;
      sel_glyph = (draw_code != '0 && !draw_code[7] && {1'b0, draw_code} < gcount_ff) ?
                  draw_code : '0;
      dec_x_col = (cls == CLS_BS) ? bs_col : cursor_col_ff;
      case (cls)
         CLS_BS:   col_pre = {1'b0, bs_col};
         CLS_CR:   col_pre = '0;
         CLS_TAB:  col_pre = 9'({1'b0, cursor_col_ff} + 9'(TAB_SIZE)
                                - ({1'b0, cursor_col_ff} % 9'(TAB_SIZE)));
         CLS_DRAW: col_pre = {1'b0, cursor_col_ff} + 9'd1;
         default:  col_pre = {1'b0, cursor_col_ff};
      endcase
      wrap    = (col_pre >= {1'b0, ncol}) && (cls != CLS_LF) && (cls != CLS_VT);
      col_sub = col_pre - {1'b0, ncol};
      col_new = wrap ? ((col_sub >= {1'b0, ncol}) ? '0 : col_sub) : col_pre;
      dec_draw   = (cls == CLS_BS) || (cls == CLS_DRAW);
      dec_check  = wrap || (cls == CLS_LF) || (cls == CLS_VT);
      dec_target = (cls == CLS_VT) ? {1'b0, cursor_line_ff} + 9'(VT_LINES) :
                                     {1'b0, cursor_line_ff} + 9'd1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_op == OP_PUT_CHAR) begin
               if (dec_draw) begin
                  state_in = ST_MUL_X;
               end else if (dec_check) begin
                  state_in = ST_LINE;
               end
            end
         end
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_FETCH;
         ST_FETCH: state_in = ST_ROWS;
         ST_ROWS: begin
            if (out_free && last_row) begin
               state_in = check_ff ? ST_LINE : ST_IDLE;
            end
         end
         ST_LINE: begin
            if (!scroll_need || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = {glyph_ff, row_ff + 5'd1};
      mul_a      = y_line_ff;
      mul_b      = gh_eff;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_MUL_X: begin
            mul_a = x_col_ff;
            mul_b = gw_eff;
         end
         ST_FETCH: begin
            rd_en   = 1'b1;
            rd_addr = {glyph_ff, {ROW_IDX_W{1'b0}}};
         end
         ST_ROWS:  rd_en = out_free && !last_row;
         default:  rd_en = 1'b0;
      endcase
   end

   assign wr_en = req_accept && (req_op == OP_LOAD_ROW);

   // datapath
   always_comb begin
      columns_in     = columns_ff;
      rows_in        = rows_ff;
      gw_in          = gw_ff;
      gh_in          = gh_ff;
      gcount_in      = gcount_ff;
      cursor_col_in  = cursor_col_ff;
      cursor_line_in = cursor_line_ff;
      glyph_in       = glyph_ff;
      x_col_in       = x_col_ff;
      y_line_in      = y_line_ff;
      check_in       = check_ff;
      target_in      = target_ff;
      row_in         = row_ff;
      base_x_in      = base_x_ff;
      base_y_in      = base_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_px_in      = rsp_px_ff;
      rsp_py_in      = rsp_py_ff;
      rsp_bits_in    = rsp_bits_ff;
      rsp_lines_in   = rsp_lines_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_COLUMNS:      columns_in = csr_wdata[COORD_W-1:0];
            CSR_ROWS:         rows_in    = csr_wdata[COORD_W-1:0];
            CSR_GLYPH_WIDTH:  gw_in      = csr_wdata[DIM_W-1:0];
            CSR_GLYPH_HEIGHT: gh_in      = csr_wdata[DIM_W-1:0];
            CSR_GLYPH_COUNT:  gcount_in  = csr_wdata;
            default:          gcount_in  = gcount_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_op == OP_PUT_CHAR) begin
               glyph_in      = sel_glyph;
               x_col_in      = dec_x_col;
               y_line_in     = cursor_line_ff;
               check_in      = dec_check;
               target_in     = dec_target;
               cursor_col_in = col_new[COORD_W-1:0];
               row_in        = '0;
            end
         end
         ST_MUL_Y: base_x_in = mul_prod + 14'd1;
         ST_FETCH: base_y_in = mul_prod;
         ST_ROWS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DRAW;
               rsp_px_in    = base_x_ff;
               rsp_py_in    = base_y_ff + {{(PIX_W-ROW_IDX_W){1'b0}}, row_ff};
               rsp_bits_in  = rd_data & row_mask;
               rsp_lines_in = '0;
               rsp_last_in  = last_row && !(check_ff && scroll_need);
               if (!last_row) begin
                  row_in = row_ff + 5'd1;
               end
            end
         end
         ST_LINE: begin
            if (!scroll_need) begin
               cursor_line_in = target_ff[COORD_W-1:0];
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_SCROLL;
               rsp_px_in      = '0;
               rsp_py_in      = '0;
               rsp_bits_in    = '0;
               rsp_lines_in   = scroll_lines;
               rsp_last_in    = 1'b1;
               cursor_line_in = nrow - 8'd1;
            end
         end
         default: row_in = row_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         columns_ff     <= RST_COLUMNS;
         rows_ff        <= RST_ROWS;
         gw_ff          <= RST_GLYPH_WIDTH;
         gh_ff          <= RST_GLYPH_HEIGHT;
         gcount_ff      <= RST_GLYPH_COUNT;
         cursor_col_ff  <= '0;
         cursor_line_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         columns_ff     <= columns_in;
         rows_ff        <= rows_in;
         gw_ff          <= gw_in;
         gh_ff          <= gh_in;
         gcount_ff      <= gcount_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_line_ff <= cursor_line_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff     <= glyph_in;
      x_col_ff     <= x_col_in;
      y_line_ff    <= y_line_in;
      check_ff     <= check_in;
      target_ff    <= target_in;
      row_ff       <= row_in;
      base_x_ff    <= base_x_in;
      base_y_ff    <= base_y_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_lines_ff <= rsp_lines_in;
   end

   tcg_ram #(
      .WIDTH (BITS_W),
      .DEPTH (FONT_DEPTH)
   ) u_font (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({req_glyph, req_row}),
      .wr_data (req_bits),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tcg_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_prod)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_lines_ff, rsp_bits_ff, rsp_py_ff, rsp_px_ff};

`ifndef SYNTH
   a_scroll_homes_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINE && scroll_need && out_free)
      |=> cursor_line_ff == $past(nrow) - 8'd1)
      else $error("cursor line not set to last line after scroll");

   a_font_read_window: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (state_ff == ST_FETCH || state_ff == ST_ROWS))
      else $error("font read outside glyph fetch");

   a_scroll_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_SCROLL) |-> rsp_last_ff)
      else $error("scroll request not marked last");

   a_row_in_glyph: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROWS) |-> ({1'b0, row_ff} <= gh_m1))
      else $error("glyph row counter past glyph height");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROWS && $past(state_ff) == ST_ROWS && !$past(out_free))
      |-> $stable(row_ff))
      else $error("row advanced while result register stalled");
`endif

endmodule

FILE: rtl/tcg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/tcg_mul.sv
// Shared cell-to-pixel multiplier with registered product.
module tcg_mul (
   input  logic                          clock,
   input  logic [tcg_pkg::COORD_W-1:0]   op_a,
   input  logic [tcg_pkg::DIM_W-1:0]     op_b,
   output logic [tcg_pkg::PIX_W-1:0]     prod_ff
);
   import tcg_pkg::*;

   logic [PIX_W-1:0] prod_in;

   assign prod_in = {{(PIX_W-COORD_W){1'b0}}, op_a} * {{(PIX_W-DIM_W){1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the text console glyph renderer: cursor, glyph draws and scrolls.
module tb_top;
   import tcg_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int MISMATCH_PRINTS = 20;

   class glyph_scoreboard;
      typedef struct packed {
         logic        kind;
         logic [13:0] px;
         logic [13:0] py;
         logic [31:0] bits;
         logic [7:0]  lines;
         logic        last;
      } result_t;

      logic [7:0]  columns, rows, col, line;
      logic [5:0]  gw, gh;
      logic [8:0]  gcount;
      logic [31:0] font [MAX_GLYPHS][MAX_GLYPH_HEIGHT];
      bit          written [MAX_GLYPHS][MAX_GLYPH_HEIGHT];
      result_t     batch[$];
      result_t     expected[$];
      int          failures, checked;

      function new();
         columns  = RST_COLUMNS;
         rows     = RST_ROWS;
         gw       = RST_GLYPH_WIDTH;
         gh       = RST_GLYPH_HEIGHT;
         gcount   = RST_GLYPH_COUNT;
         col      = 0;
         line     = 0;
         failures = 0;
         checked  = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_COLUMNS:      columns = val[7:0];
            CSR_ROWS:         rows    = val[7:0];
            CSR_GLYPH_WIDTH:  gw      = val[5:0];
            CSR_GLYPH_HEIGHT: gh      = val[5:0];
            CSR_GLYPH_COUNT:  gcount  = val;
            default: ;
         endcase
      endfunction

      function int unsigned cell_width();
         int unsigned w;
         w = (gw == 0) ? 1 : gw;
         return (w > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : w;
      endfunction

      function int unsigned glyph_rows();
         int unsigned h;
         h = (gh == 0) ? 1 : gh;
         return (h > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : h;
      endfunction

      function int unsigned glyph_of(logic [7:0] code);
         if (code > 0 && code < 128 && code < gcount && code < MAX_GLYPHS) return code;
         return 0;
      endfunction

      // true when every row the code would draw has been loaded
      function bit can_draw(logic [7:0] code);
         int unsigned g;
         case (code)
            CH_BEL, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1;
            CH_BS: g = CH_SPACE;
            default: g = glyph_of(code);
         endcase
         for (int r = 0; r < glyph_rows(); r++)
            if (!written[g][r]) return 0;
         return 1;
      endfunction

      function void draw_cell(logic [7:0] code);
         int unsigned w, h, g;
         logic [31:0] mask;
         result_t item;
         w    = cell_width();
         h    = glyph_rows();
         g    = glyph_of(code);
         mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
         for (int unsigned r = 0; r < h; r++) begin
            item.kind  = KIND_DRAW;
            item.px    = 14'(col * w + 1);
            item.py    = 14'(line * h + r);
            item.bits  = font[g][r] & mask;
            item.lines = 8'd0;
            item.last  = 1'b0;
            batch.push_back(item);
         end
      endfunction

      function void advance_line(int unsigned target);
         int unsigned nr, n;
         result_t item;
         nr = (rows == 0) ? 1 : rows;
         if (target >= nr) begin
            n = target - nr + 1;
            if (n > 255) n = 255;
            item.kind  = KIND_SCROLL;
            item.px    = 14'd0;
            item.py    = 14'd0;
            item.bits  = 32'd0;
            item.lines = n[7:0];
            item.last  = 1'b0;
            batch.push_back(item);
            target = nr - 1;
         end
         line = target[7:0];
      endfunction

      function void note_request(logic op, logic [7:0] code, logic [7:0] g, logic [4:0] r,
                                 logic [31:0] bits);
         int unsigned ncol, next_col;
         bit skip_wrap;
         result_t item;
         batch.delete();
         if (op == OP_LOAD_ROW) begin
            font[g][r]    = bits;
            written[g][r] = 1;
            return;
         end
         ncol      = (columns == 0) ? 1 : columns;
         next_col  = col;
         skip_wrap = 0;
         case (code)
            CH_BEL, CH_FF: ;
            CH_BS: begin
               if (col > 0) col = col - 1;
               draw_cell(CH_SPACE);
               next_col = col;
            end
            CH_LF: begin
               advance_line(line + 1);
               skip_wrap = 1;
            end
            CH_VT: begin
               advance_line(line + VT_LINES);
               skip_wrap = 1;
            end
            CH_CR:  next_col = 0;
            CH_TAB: next_col = col + TAB_SIZE - (col % TAB_SIZE);
            default: begin
               draw_cell(code);
               next_col = col + 1;
            end
         endcase
         if (!skip_wrap) begin
            if (next_col >= ncol) begin
               next_col -= ncol;
               if (next_col >= ncol) next_col = 0;
               col = next_col[7:0];
               advance_line(line + 1);
            end else begin
               col = next_col[7:0];
            end
         end
         foreach (batch[i]) begin
            item      = batch[i];
            item.last = (i == batch.size() - 1);
            expected.push_back(item);
         end
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            if (failures < MISMATCH_PRINTS)
               $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(logic kind, logic [RSP_DATA_W-1:0] data, logic last);
         result_t want;
         checked++;
         if (expected.size() == 0) begin
            if (failures < MISMATCH_PRINTS)
               $error("result with nothing expected: kind %0d data 0x%0h", kind, data);
            failures++;
            return;
         end
         want = expected.pop_front();
         compare("kind", want.kind, kind);
         compare("pixel_x", want.px, data[13:0]);
         compare("pixel_y", want.py, data[27:14]);
         compare("row_bits", want.bits, data[59:28]);
         compare("scroll_lines", want.lines, data[67:60]);
         compare("last", want.last, last);
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   glyph_scoreboard book = new();
   bit traffic_gaps = 1;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int n_loads      = 0;
   int n_chars      = 0;
   int n_settings   = 1;

   text_console_glyph_renderer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (traffic_gaps && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic op, input logic [7:0] code, input logic [7:0] g,
                               input logic [4:0] r, input logic [31:0] bits);
      if (traffic_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, bits, r, g, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(op, code, g, r, bits);
      if (op == OP_LOAD_ROW) n_loads++;
      else n_chars++;
   endtask

   task automatic put_char(input logic [7:0] code);
      send_request(OP_PUT_CHAR, code, 8'($urandom), 5'($urandom), $urandom);
   endtask

   task automatic load_row(input logic [7:0] g, input logic [4:0] r, input logic [31:0] bits);
      send_request(OP_LOAD_ROW, 8'($urandom), g, r, bits);
   endtask

   task automatic load_glyph(input logic [7:0] g, input int count);
      for (int r = 0; r < count; r++) load_row(g, 5'(r), $urandom);
   endtask

   // fills in the glyph first when some of its drawn rows were never loaded
   task automatic put_drawable(input logic [7:0] code);
      if (!book.can_draw(code)) load_glyph(8'(book.glyph_of(code)), book.glyph_rows());
      put_char(code);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.set_register(idx, val);
   endtask

   task automatic write_settings(input int cols, input int lines, input int w, input int h,
                                 input int count);
      wait_idle();
      csr_write(CSR_COLUMNS, 9'(cols));
      csr_write(CSR_ROWS, 9'(lines));
      csr_write(CSR_GLYPH_WIDTH, 9'(w));
      csr_write(CSR_GLYPH_HEIGHT, 9'(h));
      csr_write(CSR_GLYPH_COUNT, 9'(count));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic random_item();
      int unsigned pick;
      logic [7:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         load_glyph(8'($urandom_range(1, 127)), book.glyph_rows());
      end else if (pick < 20) begin
         load_row(8'($urandom), 5'($urandom), $urandom);
      end else if (pick < 45) begin
         case ($urandom_range(0, 6))
            0: code = CH_BEL;
            1: code = CH_BS;
            2: code = CH_TAB;
            3: code = CH_LF;
            4: code = CH_VT;
            5: code = CH_FF;
            default: code = CH_CR;
         endcase
         put_char(code);
      end else begin
         code = (pick < 70) ? 8'($urandom) : 8'($urandom_range(33, 126));
         put_drawable(code);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // glyph 0, space and 127 fully loaded; rows 0 and 1 carry all-zero and all-one bits
      for (int r = 0; r < MAX_GLYPH_HEIGHT; r++) begin
         load_row(8'd0, 5'(r), (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom);
         load_row(CH_SPACE, 5'(r), $urandom);
         load_row(8'd127, 5'(r), (r == 0) ? 32'hFFFF_FFFF : $urandom);
      end

      // default registers: every control code, glyph choice edges, clamped backspace
      put_char(CH_CR);
      put_char(CH_BS);
      put_char(8'd127);
      put_char(8'd0);
      put_char(8'd255);
      put_char(8'd128);
      put_char(CH_SPACE);
      put_char(CH_TAB);
      put_char(CH_BEL);
      put_char(CH_FF);
      put_char(CH_LF);
      put_char(CH_VT);
      put_char(CH_BS);
      repeat (10) put_char(CH_TAB);
      repeat (7) put_char(CH_VT);

      // single cell screen: every printable draw wraps and scrolls
      write_settings(1, 1, 1, 1, 1);
      put_char(8'd65);
      put_char(CH_BS);
      put_char(CH_TAB);
      put_char(CH_CR);
      put_char(CH_LF);
      put_char(CH_VT);
      put_char(8'd200);

      // largest screen and glyphs; walk the cursor to the bottom line
      write_settings(255, 255, 32, 32, 511);
      repeat (64) put_char(CH_VT);
      put_char(8'd127);
      put_drawable(8'd65);
      repeat (32) put_char(CH_TAB);
      put_char(8'd0);

      // zero registers act as one; scroll count saturates from the bottom line
      write_settings(0, 0, 0, 0, 0);
      put_char(CH_VT);
      put_drawable(8'd66);
      put_char(CH_BS);
      put_char(CH_TAB);
      put_char(CH_LF);

      write_settings(255, 3, 63, 63, 300);
      put_char(8'd255);
      put_drawable(8'd126);
      put_char(CH_CR);
      put_char(CH_BS);

      for (int p = 0; p < 7; p++) begin
         write_settings(($urandom_range(0, 5) == 0) ? 255 : $urandom_range(1, 40),
                        $urandom_range(1, 12), $urandom_range(0, 63),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(9, 63) : $urandom_range(0, 8),
                        $urandom_range(0, 511));
         if (p == 6) traffic_gaps = 0;
         repeat (40) random_item();
      end

      wait_idle();
      $display("Run covered %0d font row loads and %0d characters under %0d register settings,",
               n_loads, n_chars, n_settings);
      $display("with %0d results checked for draws, wraps, tabs and scrolls.", book.checked);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

FILE: text_console_glyph_renderer.f
rtl/tcg_pkg.sv
rtl/tcg_ram.sv
rtl/tcg_mul.sv
rtl/text_console_glyph_renderer.sv
bench/tb_top.sv
